### design/lcas_pkg.sv
// Shared types and constants for the Life generation step block.
// No dependencies; used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package lcas_pkg;

  // Grid limits and field widths
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 4096;
  localparam int MinGrid    = 3;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int CfgWidthW  = 9;
  localparam int CfgHeightW = 13;
  localparam int RowW       = 13;
  localparam int OutColW    = 8;
  localparam int OutRowW    = 12;
  localparam int CfgDataW   = CfgHeightW;
  localparam int WinW       = 9;

  localparam int GridWidthReset  = 64;
  localparam int GridHeightReset = 64;

  // Command queue between front and back end
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_CELL  = 1'b0,
    OP_FINAL = 1'b1
  } op_e;

  // Clamped grid geometry
  typedef struct packed {
    logic [CfgWidthW-1:0]  width;
    logic [CfgHeightW-1:0] height;
  } geom_t;

  // One classified command for the back end
  typedef struct packed {
    op_e                op;
    logic [ColW-1:0]    col;
    logic               alive;
    logic               row_ge1;
    logic               row_ge2;
    logic               col_zero;
    logic               emit;
    logic [OutColW-1:0] out_col;
    logic [OutRowW-1:0] out_row;
  } cmd_t;

endpackage

### design/lcas_front.sv
// Front end: tracks the raster position of arriving items and classifies each one.
// Depends on lcas_pkg; pushes commands into lcas_queue.
`timescale 1ns / 1ps

module lcas_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcas_pkg::geom_t     geom_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic                cell_alive_i,
  input  logic                q_full_i,
  output logic                push_o,
  output lcas_pkg::cmd_t      cmd_o
);

  logic [lcas_pkg::ColW-1:0] col_q, col_d;
  logic [lcas_pkg::RowW-1:0] row_q, row_d;

  logic                                accept;
  logic                                wrap;
  logic [lcas_pkg::ColW-1:0]           c0;
  logic [lcas_pkg::RowW-1:0]           r0;
  logic [lcas_pkg::RowW-1:0]           h_ext;
  logic                                ignore;
  logic                                is_final;
  logic [lcas_pkg::CfgWidthW-1:0]      nxt_col;
  logic [lcas_pkg::RowW-1:0]           row_m1;
  logic [lcas_pkg::RowW-1:0]           row_m2;
  logic [lcas_pkg::CfgWidthW-1:0]      w_m1;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign h_ext      = lcas_pkg::RowW'(geom_i.height);

  always_comb begin
    // a width that shrank mid-frame moves the position to the next row first
    wrap     = {1'b0, col_q} >= geom_i.width;
    c0       = wrap ? '0 : col_q;
    r0       = wrap ? row_q + 1'b1 : row_q;
    ignore   = kind_i ? (r0 < h_ext) : (r0 >= h_ext);
    is_final = kind_i && (r0 > h_ext);
    nxt_col  = {1'b0, c0} + 1'b1;
    row_m1   = r0 - 1'b1;
    row_m2   = r0 - 2'd2;
    w_m1     = geom_i.width - 1'b1;

    cmd_o.op       = is_final ? lcas_pkg::OP_FINAL : lcas_pkg::OP_CELL;
    cmd_o.col      = c0;
    cmd_o.alive    = kind_i ? 1'b0 : cell_alive_i;
    cmd_o.row_ge1  = r0 != '0;
    cmd_o.row_ge2  = r0 >= lcas_pkg::RowW'(2);
    cmd_o.col_zero = c0 == '0;
    cmd_o.emit     = (c0 == '0) ? cmd_o.row_ge2 : cmd_o.row_ge1;
    if (is_final || c0 == '0) begin
      cmd_o.out_col = w_m1[lcas_pkg::OutColW-1:0];
      cmd_o.out_row = row_m2[lcas_pkg::OutRowW-1:0];
    end else begin
      cmd_o.out_col = c0 - 1'b1;
      cmd_o.out_row = row_m1[lcas_pkg::OutRowW-1:0];
    end

    push_o = accept && !ignore;

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (ignore) begin
        col_d = c0;
        row_d = r0;
      end else if (is_final) begin
        col_d = '0;
        row_d = '0;
      end else if (nxt_col >= geom_i.width) begin
        col_d = '0;
        row_d = r0 + 1'b1;
      end else begin
        col_d = nxt_col[lcas_pkg::ColW-1:0];
        row_d = r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The end-of-frame drain item restarts the raster position
  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_final) |=> (col_q == '0 && row_q == '0))
    else $error("position not restarted after frame end");

endmodule

### design/lcas_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on lcas_pkg for the command type and the depth.
`timescale 1ns / 1ps

module lcas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcas_pkg::cmd_t data_i,
  input  logic           pop_i,
  output lcas_pkg::cmd_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  lcas_pkg::cmd_t               entry_q [lcas_pkg::QueueDepth];
  logic [lcas_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lcas_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lcas_pkg::QCntW-1:0]   count_q, count_d;

  assign full_o  = count_q == lcas_pkg::QCntW'(lcas_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == lcas_pkg::QPtrW'(lcas_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == lcas_pkg::QPtrW'(lcas_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from an empty queue");

endmodule

### design/lcas_back.sv
// Back end: line buffer memory, 3x3 window, Life rule and output register.
// Depends on lcas_pkg; pops commands from lcas_queue.
`timescale 1ns / 1ps

module lcas_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  lcas_pkg::cmd_t                q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          next_alive_o,
  output logic [lcas_pkg::OutColW-1:0]  out_column_o,
  output logic [lcas_pkg::OutRowW-1:0]  out_row_o,
  output logic                          frame_last_o
);

  // Entry bit 1 holds the upper line, bit 0 the middle line
  logic [1:0]                     line_mem [lcas_pkg::MaxWidth];
  logic [lcas_pkg::MaxWidth-1:0]  line_vld_q;
  logic [1:0]                     mem_rd_q;
  logic                           rd_vld_q;
  logic                           byp_q;
  logic [1:0]                     byp_data_q;

  logic                           s1_valid_q, s1_valid_d;
  lcas_pkg::cmd_t                 s1_cmd_q;
  logic [lcas_pkg::WinW-1:0]      win_q, win_d;

  logic                           out_valid_q;
  logic                           out_alive_q;
  logic [lcas_pkg::OutColW-1:0]   out_col_q;
  logic [lcas_pkg::OutRowW-1:0]   out_row_q;
  logic                           out_last_q;

  logic                           adv;
  logic                           wr_en;
  logic [1:0]                     wr_data;
  logic                           byp;
  logic [1:0]                     raw;
  logic [2:0]                     triple;
  logic [lcas_pkg::WinW-1:0]      shifted;
  logic                           result;
  logic                           emit;

  function automatic logic life_rule(logic [lcas_pkg::WinW-1:0] win);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < lcas_pkg::WinW; k++) begin
      if (k != 4) begin
        n = n + 4'(win[k]);
      end
    end
    if (win[4]) begin
      return (n == 4'd2) || (n == 4'd3);
    end
    return n == 4'd3;
  endfunction

  assign adv   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o = !q_empty_i && (!s1_valid_q || adv);

  always_comb begin
    raw     = byp_q ? byp_data_q : (rd_vld_q ? mem_rd_q : 2'b00);
    triple  = {s1_cmd_q.alive,
               s1_cmd_q.row_ge1 & raw[0],
               s1_cmd_q.row_ge2 & raw[1]};
    shifted = {3'b000, win_q[lcas_pkg::WinW-1:3]};
    wr_data = {raw[0], s1_cmd_q.alive};
    wr_en   = adv && (s1_cmd_q.op == lcas_pkg::OP_CELL);
    // a read that lands on the entry being written takes the new data
    byp     = pop_o && wr_en && (q_data_i.col == s1_cmd_q.col);

    case (s1_cmd_q.op)
      lcas_pkg::OP_FINAL: begin
        win_d  = '0;
        result = life_rule(shifted);
        emit   = 1'b1;
      end
      lcas_pkg::OP_CELL: begin
        if (s1_cmd_q.col_zero) begin
          win_d  = {triple, 6'b000000};
          result = life_rule(shifted);
        end else begin
          win_d  = {triple, win_q[lcas_pkg::WinW-1:3]};
          result = life_rule(win_d);
        end
        emit = s1_cmd_q.emit;
      end
      default: begin
        win_d  = win_q;
        result = 1'b0;
        emit   = 1'b0;
      end
    endcase

    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Line buffer memory
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mem_rd_q <= line_mem[q_data_i.col];
    end
    if (wr_en) begin
      line_mem[s1_cmd_q.col] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      byp_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        line_vld_q[s1_cmd_q.col] <= 1'b1;
      end
      if (pop_o) begin
        rd_vld_q <= line_vld_q[q_data_i.col];
        byp_q    <= byp;
      end
      s1_valid_q <= s1_valid_d;
      if (adv) begin
        win_q <= win_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cmd_q   <= q_data_i;
      byp_data_q <= wr_data;
    end
    if (adv && emit) begin
      out_alive_q <= result;
      out_col_q   <= s1_cmd_q.out_col;
      out_row_q   <= s1_cmd_q.out_row;
      out_last_q  <= s1_cmd_q.op == lcas_pkg::OP_FINAL;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = out_alive_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign frame_last_o = out_last_q;

  a_result_from_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(adv))
    else $error("result appeared without a command being carried out");

endmodule

### design/life_cellular_automaton_step.sv
// Top level of the Life generation step: configuration registers and the
// front end, command queue and back end. Depends on lcas_pkg and the lcas_* modules.
//
// Usage: cells of a grid_width x grid_height grid enter on the input channel
// (kind_i = 0) in raster order, one per clock; after the last cell, send
// grid_width + 1 flush items (kind_i = 1). Each item is a transaction taken when
// in_valid_i is high and in_stall_o is low. The next state of a cell leaves on
// the output channel one row and one column after that cell arrives, with its
// coordinates; the last flush emits the final cell with frame_last_o set.
// Throughput is one item per clock while in_stall_o is low. A result passes
// through the command queue, the line buffer read stage and the output register.
// The user must write configuration (cfg_ready_o is always high) only while idle;
// the block does not enforce it. Reset clears the position, the window, the line
// buffer valid bits and sets both grid dimensions to 64. When the receiver stalls,
// the output holds, the two-entry command queue fills, and then in_stall_o rises.
`timescale 1ns / 1ps

module life_cellular_automaton_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic                            cell_alive_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            next_alive_o,
  output logic [lcas_pkg::OutColW-1:0]    out_column_o,
  output logic [lcas_pkg::OutRowW-1:0]    out_row_o,
  output logic                            frame_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [0:0]                      cfg_index_i,
  input  logic [lcas_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [lcas_pkg::CfgWidthW-1:0]  grid_width_q;
  logic [lcas_pkg::CfgHeightW-1:0] grid_height_q;
  lcas_pkg::geom_t                 geom;

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  lcas_pkg::cmd_t  cmd_in;
  lcas_pkg::cmd_t  cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= lcas_pkg::CfgWidthW'(lcas_pkg::GridWidthReset);
      grid_height_q <= lcas_pkg::CfgHeightW'(lcas_pkg::GridHeightReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lcas_pkg::cfg_reg_e'(cfg_index_i))
        lcas_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[lcas_pkg::CfgWidthW-1:0];
        lcas_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[lcas_pkg::CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the stored dimensions to the supported range
  always_comb begin
    if (grid_width_q < lcas_pkg::CfgWidthW'(lcas_pkg::MinGrid)) begin
      geom.width = lcas_pkg::CfgWidthW'(lcas_pkg::MinGrid);
    end else if (grid_width_q > lcas_pkg::CfgWidthW'(lcas_pkg::MaxWidth)) begin
      geom.width = lcas_pkg::CfgWidthW'(lcas_pkg::MaxWidth);
    end else begin
      geom.width = grid_width_q;
    end
    if (grid_height_q < lcas_pkg::CfgHeightW'(lcas_pkg::MinGrid)) begin
      geom.height = lcas_pkg::CfgHeightW'(lcas_pkg::MinGrid);
    end else if (grid_height_q > lcas_pkg::CfgHeightW'(lcas_pkg::MaxHeight)) begin
      geom.height = lcas_pkg::CfgHeightW'(lcas_pkg::MaxHeight);
    end else begin
      geom.height = grid_height_q;
    end
  end

  lcas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .cell_alive_i (cell_alive_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  lcas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lcas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (cmd_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_last_o (frame_last_o)
  );

endmodule
